>>> hw/rtl/quaternion_normalizer_assert.svh
// Assertion macros for the quaternion normaliser.
// Used by the top level; no dependencies.
`ifndef QUATERNION_NORMALIZER_ASSERT_SVH
`define QUATERNION_NORMALIZER_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define QN_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Implication whose consequent is checked at the next clock edge.
`define QN_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> hw/rtl/qnorm_pkg.sv
// Shared constants and types for the quaternion normaliser.
// No dependencies.
`timescale 1ns / 1ps
package qnorm_pkg;
	localparam int InWidth   = 16;
	localparam int OutFrac   = 14;
	localparam int LenFrac   = 8;
	localparam int OutWidth  = 16;
	localparam int MagWidth  = InWidth;             // magnitude up to 2^15
	localparam int SumWidth  = 2 * MagWidth + 2;    // four squares
	localparam int RadWidth  = SumWidth + 2 * LenFrac; // radicand
	localparam int LenWidth  = RadWidth / 2;        // root width
	localparam int SqSteps   = LenWidth;            // one root bit per stage
	localparam int NumWidth  = MagWidth + LenFrac + OutFrac; // dividend
	localparam int DivSteps  = OutFrac + 2;         // quotient bits kept
	localparam int QWidth    = DivSteps;
	localparam int Lanes     = 4;
	localparam int Depth     = SqSteps + DivSteps + 2;

	typedef logic [MagWidth-1:0] mag_t;
	typedef logic [LenWidth-1:0] len_t;
	typedef logic [QWidth-1:0]   quo_t;
endpackage

>>> hw/rtl/qnorm_sqrt.sv
// Pipelined digit-by-digit square root, one result bit per stage.
// Depends on qnorm_pkg.
`timescale 1ns / 1ps
module qnorm_sqrt (
	input  logic                          clk,
	input  logic [qnorm_pkg::SumWidth-1:0] sum,
	output qnorm_pkg::len_t               root
);
	localparam int RW = qnorm_pkg::RadWidth;
	localparam int LW = qnorm_pkg::LenWidth;
	localparam int N  = qnorm_pkg::SqSteps;

	logic [RW-1:0] rad_s [N+1];
	logic [LW+1:0] rem_s [N+1];
	logic [LW-1:0] res_s [N+1];

	always_comb begin
		rad_s[0] = {sum, {(2 * qnorm_pkg::LenFrac){1'b0}}};
		rem_s[0] = '0;
		res_s[0] = '0;
	end

	for (genvar g = 0; g < N; g++) begin : g_step
		logic [LW+1:0] trial;
		logic [LW+1:0] cur;
		logic [LW+1:0] rem_c;
		logic [LW-1:0] res_c;
		always_comb begin
			cur   = {rem_s[g][LW-1:0], rad_s[g][RW-1 -: 2]};
			trial = {res_s[g], 2'b01};
			if (cur >= trial) begin
				rem_c = cur - trial;
				res_c = {res_s[g][LW-2:0], 1'b1};
			end else begin
				rem_c = cur;
				res_c = {res_s[g][LW-2:0], 1'b0};
			end
		end
		always_ff @(posedge clk) begin
			rad_s[g+1] <= {rad_s[g][RW-3:0], 2'b00};
			rem_s[g+1] <= rem_c;
			res_s[g+1] <= res_c;
		end
	end

	assign root = res_s[N];
endmodule

>>> hw/rtl/qnorm_div.sv
// One divider lane: restoring division, one quotient bit per stage.
// Depends on qnorm_pkg.
`timescale 1ns / 1ps
module qnorm_div (
	input  logic                          clk,
	input  logic [qnorm_pkg::NumWidth-1:0] num,
	input  qnorm_pkg::len_t               den,
	output qnorm_pkg::quo_t               quo
);
	localparam int NW = qnorm_pkg::NumWidth;
	localparam int LW = qnorm_pkg::LenWidth;
	localparam int N  = qnorm_pkg::DivSteps;
	localparam int PW = NW + 1;

	// Quotient bits above bit N-1 only matter as saturation; sticky flag.
	logic [PW-1:0] rem_s [N+1];
	logic [N-1:0]  quo_s [N+1];
	logic [LW-1:0] den_s [N+1];
	logic          big_s [N+1];

	always_comb begin
		rem_s[0] = {1'b0, num};
		quo_s[0] = '0;
		den_s[0] = den;
		// compare at full width so the shifted divisor keeps its top bits
		big_s[0] = ({{(PW+N-LW){1'b0}}, den} << N) <= {{(N+1){1'b0}}, num};
	end

	for (genvar g = 0; g < N; g++) begin : g_step
		localparam int Sh = N - 1 - g;
		logic [PW+N-1:0] dsh;
		logic            ge;
		always_comb begin
			dsh = {{(PW+N-LW){1'b0}}, den_s[g]} << Sh;
			ge  = {{N{1'b0}}, rem_s[g]} >= dsh;
		end
		always_ff @(posedge clk) begin
			rem_s[g+1] <= ge ? PW'({{N{1'b0}}, rem_s[g]} - dsh) : rem_s[g];
			quo_s[g+1] <= {quo_s[g][N-2:0], ge};
			den_s[g+1] <= den_s[g];
			big_s[g+1] <= big_s[g];
		end
	end

	assign quo = big_s[N] ? '1 : quo_s[N];
endmodule

>>> hw/rtl/quaternion_normalizer.sv
// Top level of the quaternion normaliser.
// Depends on qnorm_pkg, qnorm_sqrt, qnorm_div and the assertion header.
`timescale 1ns / 1ps
`include "quaternion_normalizer_assert.svh"
// Normalises one Q4.12 quaternion per clock to Q1.14. The datapath is a
// free-running pipeline of qnorm_pkg::Depth (43) stages: one stage takes the
// magnitudes, one sums the squares, 25 square-root stages produce the length
// one bit each, then four divider lanes run side by side for 16 stages, one
// quotient bit each, and a merging step saturates to +/- 1.0, restores signs
// and sets the zero flag. Results drop into a 64-word FIFO with a registered
// head, so a word is written to the FIFO memory and then loaded into the
// head register before it is offered. in_ready falls only once the words in
// the pipe plus those in the FIFO reach 62, so while the receiver keeps up,
// words are taken back to back at one per cycle. An all-zero input gives
// zero outputs with zero_length set.
module quaternion_normalizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic signed [15:0] w_in,
	input  logic signed [15:0] x_in,
	input  logic signed [15:0] y_in,
	input  logic signed [15:0] z_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [15:0] w_out,
	output logic signed [15:0] x_out,
	output logic signed [15:0] y_out,
	output logic signed [15:0] z_out,
	output logic        zero_length
);
	localparam int D   = qnorm_pkg::Depth;
	localparam int MW  = qnorm_pkg::MagWidth;
	localparam int SW  = qnorm_pkg::SumWidth;
	localparam int L   = qnorm_pkg::Lanes;
	localparam int QW  = qnorm_pkg::QWidth;
	localparam int OW  = qnorm_pkg::OutWidth;

	// One valid bit per pipeline stage; the pipe never stalls, the result
	// FIFO absorbs back-pressure.
	logic [D-1:0] vld_q;
	logic         take;

	logic [L-1:0][15:0] raw;
	assign raw = {z_in, y_in, x_in, w_in};

	// Stages 1 and 2: magnitudes, then sum of squares.
	qnorm_pkg::mag_t mag_s1 [L];
	logic [L-1:0]    neg_s1;
	logic [SW-1:0]   sum_c;

	always_comb begin
		sum_c = '0;
		for (int i = 0; i < L; i++) begin
			sum_c = sum_c + SW'(mag_s1[i] * mag_s1[i]);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < L; i++) begin
			neg_s1[i] <= raw[i][15];
			mag_s1[i] <= raw[i][15] ? MW'(-raw[i]) : MW'(raw[i]);
		end
	end

	logic [SW-1:0] sum_s2;
	always_ff @(posedge clk) sum_s2 <= sum_c;

	qnorm_pkg::len_t root;
	qnorm_sqrt u_sqrt (.clk(clk), .sum(sum_s2), .root(root));

	// Delay magnitudes and signs alongside the root.
	localparam int SD = qnorm_pkg::SqSteps + 1;
	qnorm_pkg::mag_t mag_d [SD+1][L];
	logic [L-1:0]    neg_d [SD+1];
	logic            zro_d [SD+1];
	always_comb begin
		mag_d[0] = mag_s1;
		neg_d[0] = neg_s1;
		zro_d[0] = 1'b0;
	end
	for (genvar g = 0; g < SD; g++) begin : g_dly
		always_ff @(posedge clk) begin
			mag_d[g+1] <= mag_d[g];
			neg_d[g+1] <= neg_d[g];
			zro_d[g+1] <= (g == 0) ? (sum_c == '0) : zro_d[g];
		end
	end

	// Four divider lanes.
	qnorm_pkg::quo_t quo [L];
	for (genvar l = 0; l < L; l++) begin : g_lane
		qnorm_div u_div (
			.clk(clk),
			.num({mag_d[SD][l], {(qnorm_pkg::LenFrac + qnorm_pkg::OutFrac){1'b0}}}),
			.den(root),
			.quo(quo[l])
		);
	end

	localparam int DD = qnorm_pkg::DivSteps;
	logic [L-1:0] neg_e [DD+1];
	logic         zro_e [DD+1];
	always_comb begin
		neg_e[0] = neg_d[SD];
		zro_e[0] = zro_d[SD];
	end
	for (genvar g = 0; g < DD; g++) begin : g_dly2
		always_ff @(posedge clk) begin
			neg_e[g+1] <= neg_e[g];
			zro_e[g+1] <= zro_e[g];
		end
	end

	// Merge logic (combinational): saturate, sign, zero flag.
	logic [L-1:0][OW-1:0] res_c;
	always_comb begin
		for (int i = 0; i < L; i++) begin
			logic [OW-1:0] m;
			m = (quo[i] > QW'(1 << qnorm_pkg::OutFrac)) ?
				OW'(1 << qnorm_pkg::OutFrac) : OW'(quo[i]);
			if (zro_e[DD]) m = '0;
			res_c[i] = neg_e[DD][i] ? -m : m;
		end
	end

	// Valid tracking and result FIFO (depth covers everything in flight).
	localparam int FD = 64;
	localparam int AW = 6;
	logic [4*OW:0] fifo_q [FD];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;
	logic [AW:0]   inflight;
	logic          push;
	logic [4*OW:0] head_q;

	assign inflight = AW'(0) + (AW+1)'($countones(vld_q));
	assign in_ready = (cnt_q + inflight) < (AW+1)'(FD - 2);
	assign take     = in_valid && in_ready;
	assign push     = vld_q[D-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[D-2:0], take};
		end
	end

	logic pop;
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) fifo_q[wp_q] <= {zro_e[DD], res_c[3], res_c[2], res_c[1], res_c[0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop || !out_valid) begin
				if (cnt_q != '0) begin
					out_valid <= 1'b1;
					rp_q <= rp_q + 1'b1;
					cnt_q <= cnt_q - 1'b1 + (AW+1)'(push);
				end else begin
					out_valid <= 1'b0;
					cnt_q <= cnt_q + (AW+1)'(push);
				end
			end else begin
				cnt_q <= cnt_q + (AW+1)'(push);
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((pop || !out_valid) && cnt_q != '0) head_q <= fifo_q[rp_q];
	end

	assign {zero_length, z_out, y_out, x_out, w_out} = head_q;

	`QN_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= (AW+1)'(FD))
	`QN_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	`QN_ASSERT_IMP(a_no_ready_full, cnt_q + inflight >= (AW+1)'(FD - 2), !in_ready)
endmodule
